// ===== rtl/erv3_pkg.sv =====
// Shared types, constants and the coefficient sequencer program for the
// vector rotation core. No dependencies.
`default_nettype none

package erv3_pkg;

   localparam int VEC_WIDTH_DEF   = 16;
   localparam int COEF_WIDTH_DEF  = 18;
   localparam int ANGLE_WIDTH_DEF = 16;

   localparam int DIM        = 3;
   localparam int NUM_COEF   = DIM * DIM;
   localparam int CSR_ADDR_W = 2;
   localparam int STEP_W     = 7;

   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE_Z = 2'd2;

   // low 32 bits of floor(pi/2 * 2^32); bit 32 is handled as an add of r
   localparam logic [31:0] HALF_PI_LO = 32'd2451551556;
   localparam logic [31:0] Q30_ONE    = 32'h4000_0000;

   localparam logic [3:0] ARG_TZ = 4'd9;
   localparam logic [3:0] ARG_TS = 4'd10;
   localparam logic [3:0] ARG_C6 = 4'd6;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LD,
      OP_XR,
      OP_X2,
      OP_DIV,
      OP_COR,
      OP_MH,
      OP_MS,
      OP_N,
      OP_SC,
      OP_MLD,
      OP_MADD,
      OP_MSUB,
      OP_MWR,
      OP_NEG,
      OP_END
   } op_type;

   typedef enum logic [2:0] {
      SRC_SX,
      SRC_CX,
      SRC_SY,
      SRC_CY,
      SRC_SZ,
      SRC_CZ,
      SRC_TZ,
      SRC_TS
   } src_type;

   typedef struct packed {
      op_type     op;
      src_type    a;
      src_type    b;
      logic [3:0] arg;
   } prog_type;

   function automatic logic [6:0] div_const(input logic [3:0] idx);
      logic [6:0] d;
      case (idx)
         4'd0:    d = 7'd72;
         4'd1:    d = 7'd42;
         4'd2:    d = 7'd20;
         4'd3:    d = 7'd6;
         4'd4:    d = 7'd90;
         4'd5:    d = 7'd56;
         4'd6:    d = 7'd30;
         4'd7:    d = 7'd12;
         default: d = 7'd2;
      endcase
      return d;
   endfunction

   // floor(2^32 / d): estimate is the true quotient or one below it
   function automatic logic [31:0] div_recip(input logic [3:0] idx);
      logic [63:0] m;
      case (idx)
         4'd0:    m = 64'd4294967296 / 72;
         4'd1:    m = 64'd4294967296 / 42;
         4'd2:    m = 64'd4294967296 / 20;
         4'd3:    m = 64'd4294967296 / 6;
         4'd4:    m = 64'd4294967296 / 90;
         4'd5:    m = 64'd4294967296 / 56;
         4'd6:    m = 64'd4294967296 / 30;
         4'd7:    m = 64'd4294967296 / 12;
         default: m = 64'd4294967296 / 2;
      endcase
      return m[31:0];
   endfunction

   function automatic prog_type pw(input op_type op, input src_type a, input src_type b,
                                   input logic [3:0] arg);
      prog_type w;
      w.op  = op;
      w.a   = a;
      w.b   = b;
      w.arg = arg;
      return w;
   endfunction

   function automatic prog_type prog_word(input logic [STEP_W-1:0] step);
      prog_type   w;
      logic [3:0] ax;
      logic [6:0] m;
      ax = {2'b00, step[6:5]};
      m  = step - 7'd96;
      w  = pw(OP_END, SRC_SX, SRC_SX, 4'd0);
      if (step < 7'd96) begin
         case (step[4:0])
            5'd0:    w = pw(OP_LD,  SRC_SX, SRC_SX, ax);
            5'd1:    w = pw(OP_XR,  SRC_SX, SRC_SX, 4'd0);
            5'd2:    w = pw(OP_X2,  SRC_SX, SRC_SX, 4'd0);
            5'd3:    w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd0);
            5'd4:    w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd5:    w = pw(OP_MH,  SRC_SX, SRC_SX, 4'd0);
            5'd6:    w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd1);
            5'd7:    w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd8:    w = pw(OP_MH,  SRC_SX, SRC_SX, 4'd0);
            5'd9:    w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd2);
            5'd10:   w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd11:   w = pw(OP_MH,  SRC_SX, SRC_SX, 4'd0);
            5'd12:   w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd3);
            5'd13:   w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd14:   w = pw(OP_MS,  SRC_SX, SRC_SX, 4'd0);
            5'd15:   w = pw(OP_N,   SRC_SX, SRC_SX, 4'd0);
            5'd16:   w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd4);
            5'd17:   w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd18:   w = pw(OP_MH,  SRC_SX, SRC_SX, 4'd0);
            5'd19:   w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd5);
            5'd20:   w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd21:   w = pw(OP_MH,  SRC_SX, SRC_SX, 4'd0);
            5'd22:   w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd6);
            5'd23:   w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd24:   w = pw(OP_MH,  SRC_SX, SRC_SX, 4'd0);
            5'd25:   w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd7);
            5'd26:   w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd27:   w = pw(OP_MH,  SRC_SX, SRC_SX, 4'd0);
            5'd28:   w = pw(OP_DIV, SRC_SX, SRC_SX, 4'd8);
            5'd29:   w = pw(OP_COR, SRC_SX, SRC_SX, 4'd0);
            5'd30:   w = pw(OP_SC,  SRC_SX, SRC_SX, ax);
            default: w = pw(OP_NOP, SRC_SX, SRC_SX, 4'd0);
         endcase
      end else begin
         case (m)
            7'd0:    w = pw(OP_MLD,  SRC_CZ, SRC_SY, 4'd0);
            7'd1:    w = pw(OP_MWR,  SRC_SX, SRC_SX, ARG_TZ);
            7'd2:    w = pw(OP_MLD,  SRC_SZ, SRC_SY, 4'd0);
            7'd3:    w = pw(OP_MWR,  SRC_SX, SRC_SX, ARG_TS);
            7'd4:    w = pw(OP_MLD,  SRC_CZ, SRC_CY, 4'd0);
            7'd5:    w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd0);
            7'd6:    w = pw(OP_MLD,  SRC_TZ, SRC_SX, 4'd0);
            7'd7:    w = pw(OP_MSUB, SRC_SZ, SRC_CX, 4'd0);
            7'd8:    w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd1);
            7'd9:    w = pw(OP_MLD,  SRC_TZ, SRC_CX, 4'd0);
            7'd10:   w = pw(OP_MADD, SRC_SZ, SRC_SX, 4'd0);
            7'd11:   w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd2);
            7'd12:   w = pw(OP_MLD,  SRC_SZ, SRC_CY, 4'd0);
            7'd13:   w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd3);
            7'd14:   w = pw(OP_MLD,  SRC_TS, SRC_SX, 4'd0);
            7'd15:   w = pw(OP_MADD, SRC_CZ, SRC_CX, 4'd0);
            7'd16:   w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd4);
            7'd17:   w = pw(OP_MLD,  SRC_TS, SRC_CX, 4'd0);
            7'd18:   w = pw(OP_MSUB, SRC_CZ, SRC_SX, 4'd0);
            7'd19:   w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd5);
            7'd20:   w = pw(OP_NEG,  SRC_SX, SRC_SX, ARG_C6);
            7'd21:   w = pw(OP_MLD,  SRC_CY, SRC_SX, 4'd0);
            7'd22:   w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd7);
            7'd23:   w = pw(OP_MLD,  SRC_CY, SRC_CX, 4'd0);
            7'd24:   w = pw(OP_MWR,  SRC_SX, SRC_SX, 4'd8);
            default: w = pw(OP_END,  SRC_SX, SRC_SX, 4'd0);
         endcase
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/erv3_coef_engine.sv =====
// Angle registers and the microcoded sequencer that forms the rotation matrix.
// Uses erv3_pkg for the program, constant tables and codes.
`default_nettype none

module erv3_coef_engine #(
   parameter int COEF_WIDTH  = erv3_pkg::COEF_WIDTH_DEF,
   parameter int ANGLE_WIDTH = erv3_pkg::ANGLE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [erv3_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [ANGLE_WIDTH-1:0]              csr_wdata,
   output logic                                     busy,
   output logic signed [COEF_WIDTH-1:0]             coef [erv3_pkg::NUM_COEF]
);

   localparam int FRAC     = COEF_WIDTH - 2;
   localparam int SC_SHIFT = 30 - FRAC;
   localparam logic [32:0] SC_HALF = (33'd1 << SC_SHIFT) >> 1;
   localparam logic signed [65:0] COEF_HALF = 66'sd1 <<< (FRAC - 1);
   localparam logic signed [65:0] COEF_ONE  = 66'sd1 <<< FRAC;

   logic [ANGLE_WIDTH-1:0]          ang_ff [3];
   logic [ANGLE_WIDTH-1:0]          ang_in [3];
   logic                            busy_ff, busy_in;
   logic [erv3_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                            phase_ff, phase_in;
   logic [29:0]                     r_ff, r_in;
   logic [2:0]                      oct_ff, oct_in;
   logic [31:0]                     x_ff, x_in, x2_ff, x2_in, h_ff, h_in;
   logic [31:0]                     n_ff, n_in, q_ff, q_in, s0_ff, s0_in;
   logic [3:0]                      dsel_ff, dsel_in;
   logic signed [COEF_WIDTH-1:0]    sin_ff [3];
   logic signed [COEF_WIDTH-1:0]    sin_in [3];
   logic signed [COEF_WIDTH-1:0]    cos_ff [3];
   logic signed [COEF_WIDTH-1:0]    cos_in [3];
   logic signed [COEF_WIDTH-1:0]    tz_ff, tz_in, ts_ff, ts_in;
   logic signed [COEF_WIDTH-1:0]    coef_ff [erv3_pkg::NUM_COEF];
   logic signed [COEF_WIDTH-1:0]    coef_in [erv3_pkg::NUM_COEF];
   logic signed [65:0]              acc_ff, acc_in, p_ff, p_in;

   erv3_pkg::prog_type              word;
   logic signed [32:0]              mul_a, mul_b, src_a, src_b;
   logic [31:0]                     turn;
   logic [39:0]                     rem;
   logic [6:0]                      dv;
   logic [31:0]                     qc, sm, cm;
   logic [32:0]                     sr, cr;
   logic [COEF_WIDTH-1:0]           smag, cmag;
   logic                            swap, s_neg, c_neg, wr_ok;
   logic signed [65:0]              rnd;
   logic signed [COEF_WIDTH-1:0]    cval;

   assign word = erv3_pkg::prog_word(step_ff);

   function automatic logic signed [32:0] pick(input erv3_pkg::src_type s,
                                               input logic signed [COEF_WIDTH-1:0] sx,
                                               input logic signed [COEF_WIDTH-1:0] cx,
                                               input logic signed [COEF_WIDTH-1:0] sy,
                                               input logic signed [COEF_WIDTH-1:0] cy,
                                               input logic signed [COEF_WIDTH-1:0] sz,
                                               input logic signed [COEF_WIDTH-1:0] cz,
                                               input logic signed [COEF_WIDTH-1:0] tz,
                                               input logic signed [COEF_WIDTH-1:0] ts);
      logic signed [COEF_WIDTH-1:0] v;
      case (s)
         erv3_pkg::SRC_SX: v = sx;
         erv3_pkg::SRC_CX: v = cx;
         erv3_pkg::SRC_SY: v = sy;
         erv3_pkg::SRC_CY: v = cy;
         erv3_pkg::SRC_SZ: v = sz;
         erv3_pkg::SRC_CZ: v = cz;
         erv3_pkg::SRC_TZ: v = tz;
         default:          v = ts;
      endcase
      return 33'(v);
   endfunction

   assign src_a = pick(word.a, sin_ff[0], cos_ff[0], sin_ff[1], cos_ff[1],
                       sin_ff[2], cos_ff[2], tz_ff, ts_ff);
   assign src_b = pick(word.b, sin_ff[0], cos_ff[0], sin_ff[1], cos_ff[1],
                       sin_ff[2], cos_ff[2], tz_ff, ts_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (word.op)
         erv3_pkg::OP_XR: begin
            mul_a = {3'b000, r_ff};
            mul_b = {1'b0, erv3_pkg::HALF_PI_LO};
         end
         erv3_pkg::OP_X2: begin
            mul_a = {1'b0, x_ff};
            mul_b = {1'b0, x_ff};
         end
         erv3_pkg::OP_DIV: begin
            mul_a = {1'b0, n_ff};
            mul_b = {1'b0, erv3_pkg::div_recip(word.arg)};
         end
         erv3_pkg::OP_MH: begin
            mul_a = {1'b0, x2_ff};
            mul_b = {1'b0, h_ff};
         end
         erv3_pkg::OP_MS: begin
            mul_a = {1'b0, x_ff};
            mul_b = {1'b0, h_ff};
         end
         erv3_pkg::OP_MLD, erv3_pkg::OP_MADD, erv3_pkg::OP_MSUB: begin
            mul_a = src_a;
            mul_b = src_b;
         end
         default: begin
         end
      endcase
   end

   assign p_in = mul_a * mul_b;

   always_comb begin
      turn  = {ang_ff[word.arg[1:0]], {(32 - ANGLE_WIDTH){1'b0}}};
      dv    = erv3_pkg::div_const(dsel_ff);
      rem   = {8'd0, n_ff} - (40'(q_ff) * 40'(dv));
      qc    = q_ff + 32'(rem >= 40'(dv));
      swap  = (oct_ff == 3'd1) || (oct_ff == 3'd2) || (oct_ff == 3'd5) || (oct_ff == 3'd6);
      sm    = swap ? h_ff : s0_ff;
      cm    = swap ? s0_ff : h_ff;
      sr    = ({1'b0, sm} + SC_HALF) >> SC_SHIFT;
      cr    = ({1'b0, cm} + SC_HALF) >> SC_SHIFT;
      smag  = sr[COEF_WIDTH-1:0];
      cmag  = cr[COEF_WIDTH-1:0];
      s_neg = oct_ff[2];
      c_neg = (oct_ff == 3'd2) || (oct_ff == 3'd3) || (oct_ff == 3'd4) || (oct_ff == 3'd5);
      rnd   = (acc_ff + COEF_HALF) >>> FRAC;
      if (rnd > COEF_ONE) begin
         cval = COEF_WIDTH'(COEF_ONE);
      end else if (rnd < -COEF_ONE) begin
         cval = COEF_WIDTH'(-COEF_ONE);
      end else begin
         cval = rnd[COEF_WIDTH-1:0];
      end
      wr_ok = csr_we && ((csr_addr == erv3_pkg::REG_ANGLE_X) ||
                         (csr_addr == erv3_pkg::REG_ANGLE_Y) ||
                         (csr_addr == erv3_pkg::REG_ANGLE_Z));
   end

   always_comb begin
      ang_in   = ang_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      r_in     = r_ff;
      oct_in   = oct_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      h_in     = h_ff;
      n_in     = n_ff;
      q_in     = q_ff;
      s0_in    = s0_ff;
      dsel_in  = dsel_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      tz_in    = tz_ff;
      ts_in    = ts_ff;
      coef_in  = coef_ff;
      acc_in   = acc_ff;
      if (busy_ff) begin
         phase_in = ~phase_ff;
         if (phase_ff) begin
            step_in = step_ff + 1'b1;
            case (word.op)
               erv3_pkg::OP_LD: begin
                  oct_in = turn[31:29];
                  r_in   = turn[29] ? (30'h2000_0000 - {1'b0, turn[28:0]})
                                    : {1'b0, turn[28:0]};
               end
               erv3_pkg::OP_XR:  x_in = {2'b00, r_ff} + p_ff[63:32];
               erv3_pkg::OP_X2: begin
                  x2_in = p_ff[61:30];
                  n_in  = p_ff[61:30];
               end
               erv3_pkg::OP_DIV: begin
                  q_in    = p_ff[63:32];
                  dsel_in = word.arg;
               end
               erv3_pkg::OP_COR: h_in  = erv3_pkg::Q30_ONE - qc;
               erv3_pkg::OP_MH:  n_in  = p_ff[61:30];
               erv3_pkg::OP_MS:  s0_in = p_ff[61:30];
               erv3_pkg::OP_N:   n_in  = x2_ff;
               erv3_pkg::OP_SC: begin
                  sin_in[word.arg[1:0]] = s_neg ? -smag : smag;
                  cos_in[word.arg[1:0]] = c_neg ? -cmag : cmag;
               end
               erv3_pkg::OP_MLD:  acc_in = p_ff;
               erv3_pkg::OP_MADD: acc_in = acc_ff + p_ff;
               erv3_pkg::OP_MSUB: acc_in = acc_ff - p_ff;
               erv3_pkg::OP_MWR: begin
                  if (word.arg == erv3_pkg::ARG_TZ) begin
                     tz_in = cval;
                  end else if (word.arg == erv3_pkg::ARG_TS) begin
                     ts_in = cval;
                  end else begin
                     coef_in[word.arg] = cval;
                  end
               end
               erv3_pkg::OP_NEG: coef_in[word.arg] = -sin_ff[1];
               erv3_pkg::OP_END: busy_in = 1'b0;
               default: begin
               end
            endcase
         end
      end
      if (wr_ok) begin
         ang_in[csr_addr] = csr_wdata;
         busy_in  = 1'b1;
         step_in  = '0;
         phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      r_ff    <= r_in;
      oct_ff  <= oct_in;
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      h_ff    <= h_in;
      n_ff    <= n_in;
      q_ff    <= q_in;
      s0_ff   <= s0_in;
      dsel_ff <= dsel_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
      tz_ff   <= tz_in;
      ts_ff   <= ts_in;
      acc_ff  <= acc_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         phase_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            ang_ff[i] <= '0;
         end
         for (int i = 0; i < erv3_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= (i % 4 == 0) ? COEF_WIDTH'(COEF_ONE) : '0;
         end
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         ang_ff   <= ang_in;
         coef_ff  <= coef_in;
      end
   end

   assign busy = busy_ff;
   assign coef = coef_ff;

endmodule

`default_nettype wire

// ===== rtl/euler_rotate_vector3_core.sv =====
// An accepted item passes the product, row-sum and round registers to rsp_*.
// Throughput: one item per cycle through the multiply, row-sum and round stages,
// unless rsp_tready stalls. After each angle write the coefficient sequencer runs
// on its one shared multiplier; req_tready stays low during that time.
// Reset (synchronous): angles zero, identity matrix loaded at once, pipeline empty.
// Top level of the vector rotation core; uses erv3_pkg and erv3_coef_engine.
`default_nettype none

module euler_rotate_vector3_core #(
   parameter int VEC_WIDTH   = erv3_pkg::VEC_WIDTH_DEF,
   parameter int COEF_WIDTH  = erv3_pkg::COEF_WIDTH_DEF,
   parameter int ANGLE_WIDTH = erv3_pkg::ANGLE_WIDTH_DEF,
   localparam int REQ_W = ((3 * VEC_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((3 * (VEC_WIDTH + 1) + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [erv3_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [ANGLE_WIDTH-1:0]          csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [REQ_W-1:0]                req_tdata,  // vec_x, vec_y, vec_z, zero pad
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [RSP_W-1:0]                     rsp_tdata   // rot_x, rot_y, rot_z, zero pad
);

   localparam int FRAC   = COEF_WIDTH - 2;
   localparam int PROD_W = COEF_WIDTH + VEC_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam int OUT_W  = VEC_WIDTH + 1;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC - 1);
   localparam logic signed [ACC_W-1:0] OUT_MAX  =
      {{(ACC_W - VEC_WIDTH){1'b0}}, {VEC_WIDTH{1'b1}}};
   localparam logic signed [ACC_W-1:0] OUT_MIN  = ~OUT_MAX;

   logic                            busy;
   logic signed [COEF_WIDTH-1:0]    coef [erv3_pkg::NUM_COEF];

   logic                            v1_ff, v2_ff, v3_ff;
   logic                            en1, en2, en3, accept;
   logic signed [VEC_WIDTH-1:0]     vec [3];
   logic signed [PROD_W-1:0]        prod_ff [erv3_pkg::NUM_COEF];
   logic signed [PROD_W-1:0]        prod_in [erv3_pkg::NUM_COEF];
   logic signed [ACC_W-1:0]         sum_ff [3];
   logic signed [ACC_W-1:0]         sum_in [3];
   logic signed [ACC_W-1:0]         rs [3];
   logic signed [OUT_W-1:0]         rot_ff [3];
   logic signed [OUT_W-1:0]         rot_in [3];

   erv3_coef_engine #(
      .COEF_WIDTH  (COEF_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .coef      (coef)
   );

   assign en3        = !v3_ff || rsp_tready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1 && !busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         vec[j] = req_tdata[j*VEC_WIDTH +: VEC_WIDTH];
      end
      for (int k = 0; k < erv3_pkg::NUM_COEF; k++) begin
         prod_in[k] = PROD_W'(coef[k]) * PROD_W'(vec[k % 3]);
      end
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = ACC_W'(prod_ff[3*i]) + ACC_W'(prod_ff[3*i+1]) + ACC_W'(prod_ff[3*i+2]);
         rs[i]     = (sum_ff[i] + RND_HALF) >>> FRAC;
         if (rs[i] > OUT_MAX) begin
            rot_in[i] = OUT_W'(OUT_MAX);
         end else if (rs[i] < OUT_MIN) begin
            rot_in[i] = OUT_W'(OUT_MIN);
         end else begin
            rot_in[i] = rs[i][OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= prod_in;
      end
      if (en2 && v1_ff) begin
         sum_ff <= sum_in;
      end
      if (en3 && v2_ff) begin
         rot_ff <= rot_in;
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= accept;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = RSP_W'({rot_ff[2], rot_ff[1], rot_ff[0]});

`ifndef NO_ASSERTIONS
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("item taken while coefficients are being formed");

   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_addr == erv3_pkg::REG_ANGLE_X || csr_addr == erv3_pkg::REG_ANGLE_Y ||
                  csr_addr == erv3_pkg::REG_ANGLE_Z)) |=> busy)
      else $error("angle write did not start the sequencer");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted item lost at first stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !busy))
      else $error("reset left pipeline or sequencer active");
`endif

endmodule

`default_nettype wire
